/* hw/rtl/dlps_pkg.sv */
// Shared constants, register codes, control structs and the sequencer state type
// for the dual-link paced scheduler. No dependencies.
package dlps_pkg;

   // Field widths
   localparam int NOW_W         = 64;
   localparam int LEN_W         = 16;
   localparam int BW_W          = 24;
   localparam int WEIGHT_W      = 16;
   localparam int PACE_USEC_W   = 32;

   // Block constants
   localparam int OVERHEAD_BYTES = 20;
   localparam int QUEUE_DEPTH    = 1024;
   localparam int PACE_SCALE     = 8000;
   localparam int WEIGHT_DIVISOR = 8 * 10;

   localparam int DEPTH_W       = $clog2(QUEUE_DEPTH + 1);

   // Largest pacing dividend, (max length + overhead) * scale
   localparam int DIVIDEND_MAX  = (2 ** LEN_W - 1 + OVERHEAD_BYTES) * PACE_SCALE;
   localparam int DIVIDEND_W    = $clog2(DIVIDEND_MAX + 1);
   localparam int DIV_CNT_W     = $clog2(DIVIDEND_W);

   // (depth + 1) * divisor, used for the derived threshold test
   localparam int THR_PROD_W    = DEPTH_W + 1 + $clog2(WEIGHT_DIVISOR);

   // Digit-serial time arithmetic
   localparam int DIGIT_W       = 8;
   localparam int DIGITS        = NOW_W / DIGIT_W;
   localparam int DIGIT_CNT_W   = $clog2(DIGITS);

   // Configuration port
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIMARY_BW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECONDARY_BW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIMARY_WEIGHT = 2'd2;

   typedef struct packed {
      logic [BW_W-1:0]     primary_bw;
      logic [BW_W-1:0]     secondary_bw;
      logic [WEIGHT_W-1:0] primary_weight;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic cmp_step;
      logic pace_load;
      logic upd_step;
      logic upd_sec;
      logic commit;
   } time_ctl_type;

   typedef struct packed {
      logic primary_due;
      logic secondary_due;
   } time_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_DECIDE,
      ST_DIV,
      ST_UPD,
      ST_COMMIT,
      ST_FINISH
   } state_type;

endpackage

/* hw/rtl/dlps_if.sv */
// Valid/ready channel interfaces for requests, results and configuration writes.
// Depends on dlps_pkg for the field widths.
interface dlps_req_if;
   logic                             valid;
   logic                             ready;
   logic [dlps_pkg::NOW_W-1:0]       now_usec;
   logic [dlps_pkg::DEPTH_W-1:0]     queue_depth;
   logic [dlps_pkg::LEN_W-1:0]       head_length;
   logic                             primary_up;
   logic                             secondary_up;
   logic                             primary_testing;
   logic                             secondary_testing;

   modport source (output valid, now_usec, queue_depth, head_length, primary_up,
                   secondary_up, primary_testing, secondary_testing, input ready);
   modport sink   (input valid, now_usec, queue_depth, head_length, primary_up,
                   secondary_up, primary_testing, secondary_testing, output ready);
endinterface

interface dlps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             send_now;
   logic                             use_secondary;
   logic [dlps_pkg::PACE_USEC_W-1:0] pace_usec;

   modport source (output valid, send_now, use_secondary, pace_usec, input ready);
   modport sink   (input valid, send_now, use_secondary, pace_usec, output ready);
endinterface

interface dlps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dlps_pkg::CSR_IDX_W-1:0]   index;
   logic [dlps_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/dlps_csr.sv */
// Configuration registers: link bandwidths and the primary weight.
// Depends on dlps_pkg and dlps_csr_if.
module dlps_csr (
   input  logic              clock,
   input  logic              reset,
   dlps_csr_if.sink          csr_if,
   output dlps_pkg::cfg_type cfg
);

   dlps_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            dlps_pkg::CSR_PRIMARY_BW: begin
               cfg_in.primary_bw = csr_if.data[dlps_pkg::BW_W-1:0];
            end
            dlps_pkg::CSR_SECONDARY_BW: begin
               cfg_in.secondary_bw = csr_if.data[dlps_pkg::BW_W-1:0];
            end
            dlps_pkg::CSR_PRIMARY_WEIGHT: begin
               cfg_in.primary_weight = csr_if.data[dlps_pkg::WEIGHT_W-1:0];
            end
            default: begin
               // Writes to unknown indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/dlps_divider.sv */
// Radix-2 restoring divider producing one quotient bit per cycle.
// Depends on dlps_pkg for the dividend and divisor widths.
module dlps_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dlps_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [dlps_pkg::BW_W-1:0]         divisor,
   output logic                              done,
   output logic [dlps_pkg::DIVIDEND_W-1:0]   quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [dlps_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [dlps_pkg::BW_W-1:0]         rem_ff, rem_in;
   logic [dlps_pkg::BW_W-1:0]         dvs_ff, dvs_in;
   logic [dlps_pkg::DIVIDEND_W-1:0]   q_ff, q_in;
   logic [dlps_pkg::BW_W:0]           trial;
   logic [dlps_pkg::BW_W:0]           diff;
   logic                              ge;

   assign done     = done_ff;
   assign quotient = q_ff;

   // The dividend shifts out of the quotient register from the top while
   // quotient bits enter at the bottom.
   always_comb begin
      trial = {rem_ff, q_ff[dlps_pkg::DIVIDEND_W-1]};
      ge    = (trial >= {1'b0, dvs_ff});
      diff  = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         q_in    = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[dlps_pkg::BW_W-1:0] : trial[dlps_pkg::BW_W-1:0];
         q_in   = {q_ff[dlps_pkg::DIVIDEND_W-2:0], ge};
         if (cnt_ff == dlps_pkg::DIV_CNT_W'(dlps_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end

endmodule

/* hw/rtl/dlps_time_unit.sv */
// Digit-serial time arithmetic: holds both next-send times, compares them with
// the current time and applies the pacing update. Depends on dlps_pkg.
module dlps_time_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  dlps_pkg::time_ctl_type            ctl,
   input  logic [dlps_pkg::NOW_W-1:0]        now_usec,
   input  logic [dlps_pkg::DIVIDEND_W-1:0]   pace,
   output dlps_pkg::time_sts_type            sts
);

   localparam int DW  = dlps_pkg::DIGIT_W;
   localparam int NW  = dlps_pkg::NOW_W;
   localparam int PW  = dlps_pkg::PACE_USEC_W;

   logic [NW-1:0] now_ff, now_in;
   logic [NW-1:0] pnext_ff, pnext_in;
   logic [NW-1:0] snext_ff, snext_in;
   logic [PW-1:0] pace_ff, pace_in;
   logic          bp_ff, bp_in, bs_ff, bs_in;
   logic          bl_ff, bl_in, bd_ff, bd_in;
   logic          ca_ff, ca_in, cb_ff, cb_in;
   logic [DW-1:0] now_d, p_d, s_d, nx_d, pace_d, late_d;
   logic [DW:0]   sub_p, sub_s, sub_l, sub_d, sum_a, sum_b;

   assign sts.primary_due   = ~bp_ff;
   assign sts.secondary_due = ~bs_ff;

   // One digit of each running operation, least significant digit first.
   always_comb begin
      now_d  = now_ff[DW-1:0];
      p_d    = pnext_ff[DW-1:0];
      s_d    = snext_ff[DW-1:0];
      nx_d   = ctl.upd_sec ? s_d : p_d;
      pace_d = pace_ff[DW-1:0];
      sub_p  = {1'b0, now_d} - {1'b0, p_d} - (DW+1)'(bp_ff);
      sub_s  = {1'b0, now_d} - {1'b0, s_d} - (DW+1)'(bs_ff);
      sub_l  = {1'b0, now_d} - {1'b0, nx_d} - (DW+1)'(bl_ff);
      late_d = sub_l[DW-1:0];
      // A final borrow here means the lateness exceeds the pacing time.
      sub_d  = {1'b0, pace_d} - {1'b0, late_d} - (DW+1)'(bd_ff);
      sum_a  = {1'b0, now_d} + {1'b0, pace_d} + (DW+1)'(ca_ff);
      sum_b  = {1'b0, nx_d} + {1'b0, pace_d} + (DW+1)'(cb_ff);
   end

   always_comb begin
      now_in   = now_ff;
      pnext_in = pnext_ff;
      snext_in = snext_ff;
      pace_in  = pace_ff;
      bp_in    = bp_ff;
      bs_in    = bs_ff;
      bl_in    = bl_ff;
      bd_in    = bd_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      if (ctl.load) begin
         now_in = now_usec;
         bp_in  = 1'b0;
         bs_in  = 1'b0;
         bl_in  = 1'b0;
         bd_in  = 1'b0;
         ca_in  = 1'b0;
         cb_in  = 1'b0;
      end
      // The compare pass rotates all three words, so they are intact afterwards.
      if (ctl.cmp_step) begin
         now_in   = {now_d, now_ff[NW-1:DW]};
         pnext_in = {p_d, pnext_ff[NW-1:DW]};
         snext_in = {s_d, snext_ff[NW-1:DW]};
         bp_in    = sub_p[DW];
         bs_in    = sub_s[DW];
      end
      if (ctl.pace_load) begin
         pace_in = PW'(pace);
      end
      // The update pass leaves now + pace in the time register and
      // next + pace in the chosen link's register.
      if (ctl.upd_step) begin
         now_in  = {sum_a[DW-1:0], now_ff[NW-1:DW]};
         pace_in = {{DW{1'b0}}, pace_ff[PW-1:DW]};
         if (ctl.upd_sec) begin
            snext_in = {sum_b[DW-1:0], snext_ff[NW-1:DW]};
         end else begin
            pnext_in = {sum_b[DW-1:0], pnext_ff[NW-1:DW]};
         end
         bl_in = sub_l[DW];
         bd_in = sub_d[DW];
         ca_in = sum_a[DW];
         cb_in = sum_b[DW];
      end
      if (ctl.commit && bd_ff) begin
         if (ctl.upd_sec) begin
            snext_in = now_ff;
         end else begin
            pnext_in = now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pnext_ff <= '0;
         snext_ff <= '0;
         bp_ff    <= 1'b0;
         bs_ff    <= 1'b0;
         bl_ff    <= 1'b0;
         bd_ff    <= 1'b0;
         ca_ff    <= 1'b0;
         cb_ff    <= 1'b0;
      end else begin
         pnext_ff <= pnext_in;
         snext_ff <= snext_in;
         bp_ff    <= bp_in;
         bs_ff    <= bs_in;
         bl_ff    <= bl_in;
         bd_ff    <= bd_in;
         ca_ff    <= ca_in;
         cb_ff    <= cb_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      pace_ff <= pace_in;
   end

endmodule

/* hw/rtl/dual_link_paced_scheduler.sv */
// Dual-link paced scheduler, top level; uses dlps_pkg, dlps_if, dlps_csr,
// dlps_divider and dlps_time_unit. A request passes an 8-digit time compare;
// one whose packet is sent also passes a bit-serial division and an 8-digit time
// update. One request is handled at a time; the result register lets the next
// request in while a result waits. Synchronous reset clears all link state.
module dual_link_paced_scheduler (
   input  logic        clock,
   input  logic        reset,
   dlps_req_if.sink    req_if,
   dlps_rsp_if.source  rsp_if,
   dlps_csr_if.sink    csr_if
);

   dlps_pkg::cfg_type       cfg;
   dlps_pkg::time_ctl_type  tctl;
   dlps_pkg::time_sts_type  tsts;
   dlps_pkg::state_type     state_ff, state_in;

   logic [dlps_pkg::DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                             digit_last;
   logic                             req_acc;
   logic                             slot_free;
   logic                             out_load;
   logic                             div_start;
   logic                             div_done;
   logic [dlps_pkg::DIVIDEND_W-1:0]  quotient;
   logic [dlps_pkg::BW_W-1:0]        divisor;

   // Per-request flags captured at acceptance
   logic                             depth_nz_ff, p_ok_ff, s_ok_ff, below_ff;
   logic                             p_ok_in, s_ok_in, below_in;
   logic [dlps_pkg::DIVIDEND_W-1:0]  dividend_ff, dividend_in;
   logic [dlps_pkg::THR_PROD_W-1:0]  thr_prod;

   // Decision
   logic                             have_ff, sec_ff, send_ff;
   logic                             have_calc, sec_calc, send_calc;

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_send_ff, rsp_sec_ff;
   logic [dlps_pkg::PACE_USEC_W-1:0] rsp_pace_ff;

   dlps_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   dlps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   dlps_time_unit u_time (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tctl),
      .now_usec (req_if.now_usec),
      .pace     (quotient),
      .sts      (tsts)
   );

   assign req_acc    = req_if.valid && req_if.ready;
   assign slot_free  = !rsp_valid_ff || rsp_if.ready;
   assign digit_last = (cnt_ff == dlps_pkg::DIGIT_CNT_W'(dlps_pkg::DIGITS - 1));

   // Link usability and the queue threshold test. With a zero weight the
   // threshold is bandwidth / 80, and depth < floor(bw / 80) holds exactly
   // when (depth + 1) * 80 <= bw.
   always_comb begin
      p_ok_in  = req_if.primary_up && (cfg.primary_bw != '0) && !req_if.primary_testing;
      s_ok_in  = req_if.secondary_up && (cfg.secondary_bw != '0)
                 && !req_if.secondary_testing;
      thr_prod = dlps_pkg::THR_PROD_W'(
                    (dlps_pkg::THR_PROD_W'(req_if.queue_depth) + 1'b1)
                    * dlps_pkg::THR_PROD_W'(dlps_pkg::WEIGHT_DIVISOR));
      if (cfg.primary_weight != '0) begin
         below_in = (dlps_pkg::WEIGHT_W'(req_if.queue_depth) < cfg.primary_weight);
      end else begin
         below_in = (dlps_pkg::BW_W'(thr_prod) <= cfg.primary_bw);
      end
      dividend_in = dlps_pkg::DIVIDEND_W'(
                       (dlps_pkg::DIVIDEND_W'(req_if.head_length)
                        + dlps_pkg::DIVIDEND_W'(dlps_pkg::OVERHEAD_BYTES))
                       * dlps_pkg::DIVIDEND_W'(dlps_pkg::PACE_SCALE));
   end

   // Link choice, valid once the compare pass has finished.
   always_comb begin
      if (p_ok_ff && s_ok_ff) begin
         sec_calc = !(below_ff || tsts.primary_due);
      end else begin
         sec_calc = !p_ok_ff && s_ok_ff;
      end
      have_calc = depth_nz_ff && (p_ok_ff || s_ok_ff);
      send_calc = have_calc && (sec_calc ? tsts.secondary_due : tsts.primary_due);
      divisor   = sec_calc ? cfg.secondary_bw : cfg.primary_bw;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dlps_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = dlps_pkg::ST_CMP;
            end
         end
         dlps_pkg::ST_CMP: begin
            if (digit_last) begin
               state_in = dlps_pkg::ST_DECIDE;
            end
         end
         dlps_pkg::ST_DECIDE: begin
            state_in = send_calc ? dlps_pkg::ST_DIV : dlps_pkg::ST_FINISH;
         end
         dlps_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = dlps_pkg::ST_UPD;
            end
         end
         dlps_pkg::ST_UPD: begin
            if (digit_last) begin
               state_in = dlps_pkg::ST_COMMIT;
            end
         end
         dlps_pkg::ST_COMMIT: begin
            state_in = dlps_pkg::ST_FINISH;
         end
         dlps_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = dlps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dlps_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_if.ready   = 1'b0;
      tctl           = '0;
      tctl.upd_sec   = sec_ff;
      div_start      = 1'b0;
      out_load       = 1'b0;
      case (state_ff)
         dlps_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            tctl.load    = req_if.valid;
         end
         dlps_pkg::ST_CMP: begin
            tctl.cmp_step = 1'b1;
         end
         dlps_pkg::ST_DECIDE: begin
            div_start = send_calc;
         end
         dlps_pkg::ST_DIV: begin
            tctl.pace_load = div_done;
         end
         dlps_pkg::ST_UPD: begin
            tctl.upd_step = 1'b1;
         end
         dlps_pkg::ST_COMMIT: begin
            tctl.commit = 1'b1;
         end
         dlps_pkg::ST_FINISH: begin
            out_load = slot_free;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == dlps_pkg::ST_CMP || state_ff == dlps_pkg::ST_UPD) begin
         cnt_in = digit_last ? '0 : cnt_ff + 1'b1;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlps_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         depth_nz_ff <= (req_if.queue_depth != '0);
         p_ok_ff     <= p_ok_in;
         s_ok_ff     <= s_ok_in;
         below_ff    <= below_in;
         dividend_ff <= dividend_in;
      end
      if (state_ff == dlps_pkg::ST_DECIDE) begin
         have_ff <= have_calc;
         sec_ff  <= sec_calc;
         send_ff <= send_calc;
      end
      if (out_load) begin
         rsp_send_ff <= send_ff;
         rsp_sec_ff  <= have_ff && sec_ff;
         rsp_pace_ff <= send_ff ? dlps_pkg::PACE_USEC_W'(quotient) : '0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.send_now      = rsp_send_ff;
   assign rsp_if.use_secondary = rsp_sec_ff;
   assign rsp_if.pace_usec     = rsp_pace_ff;

`ifndef ASSERT_OFF
   // A result that sends nothing never charges a pacing time.
   a_idle_no_pace: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.send_now |-> rsp_if.pace_usec == '0)
      else $error("pacing time reported without a send");

   // The time update only runs for a request that is actually sent.
   a_update_needs_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dlps_pkg::ST_UPD || state_ff == dlps_pkg::ST_COMMIT) |-> send_ff)
      else $error("next-send time updated for a request that is not sent");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == dlps_pkg::ST_DIV)
      else $error("divider finished outside the division state");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the dual-link paced scheduler.
// Depends on dlps_pkg, the channel interfaces in dlps_if and the scheduler RTL.
// Requests are predicted in order of acceptance and checked against each result.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [dlps_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int END_SETTLE       = 60;
   localparam int ITEMS_PER_PHASE  = 320;
   localparam int ITEMS_PER_CONFIG = 40;

   typedef struct packed {
      logic [dlps_pkg::NOW_W-1:0]   now_usec;
      logic [dlps_pkg::DEPTH_W-1:0] queue_depth;
      logic [dlps_pkg::LEN_W-1:0]   head_length;
      logic                         primary_up;
      logic                         secondary_up;
      logic                         primary_testing;
      logic                         secondary_testing;
   } sched_request_type;

   typedef struct packed {
      logic                             send_now;
      logic                             use_secondary;
      logic [dlps_pkg::PACE_USEC_W-1:0] pace_usec;
   } sched_result_type;

   logic clock;
   logic reset;

   dlps_req_if req_ch ();
   dlps_rsp_if rsp_ch ();
   dlps_csr_if csr_ch ();

   dual_link_paced_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Predictor copy of the registers and of the per-link send schedule
   dlps_pkg::cfg_type            link_cfg;
   logic [dlps_pkg::NOW_W-1:0]   primary_next_at;
   logic [dlps_pkg::NOW_W-1:0]   secondary_next_at;
   logic [dlps_pkg::NOW_W-1:0]   stream_now;

   sched_result_type  expected_results[$];
   sched_result_type  oldest_result;

   int  req_gap_pct;
   int  rsp_stall_pct;
   bit  long_hold_pending;
   int  hold_left;
   int  idle_cycles;
   int  mismatch_count;
   int  requests_sent;
   int  results_seen;
   int  sends_seen;
   int  csr_writes;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      $display("MISMATCH result %0d: %s expected 0x%0h got 0x%0h",
               results_seen, what, want, got);
   endtask

   function automatic logic [63:0] depth_threshold();
      if (link_cfg.primary_weight != '0)
         return 64'(link_cfg.primary_weight);
      return 64'(link_cfg.primary_bw / dlps_pkg::WEIGHT_DIVISOR);
   endfunction

   // Works out the decision for one request and advances the chosen link's schedule.
   function automatic sched_result_type predict_decision(input sched_request_type r);
      logic                       p_ok, s_ok, have, sec;
      logic [dlps_pkg::NOW_W-1:0] next_at, late, pace;
      logic [dlps_pkg::BW_W-1:0]  bw;
      sched_result_type           res;
      res  = '0;
      have = 1'b0;
      sec  = 1'b0;
      p_ok = r.primary_up && (link_cfg.primary_bw != '0) && !r.primary_testing;
      s_ok = r.secondary_up && (link_cfg.secondary_bw != '0) && !r.secondary_testing;
      if (r.queue_depth != '0) begin
         if (p_ok && s_ok) begin
            have = 1'b1;
            sec  = !((64'(r.queue_depth) < depth_threshold()) ||
                     (r.now_usec >= primary_next_at));
         end else if (p_ok) begin
            have = 1'b1;
         end else if (s_ok) begin
            have = 1'b1;
            sec  = 1'b1;
         end
         if (have) begin
            next_at = sec ? secondary_next_at : primary_next_at;
            bw      = sec ? link_cfg.secondary_bw : link_cfg.primary_bw;
            if (r.now_usec >= next_at) begin
               late = r.now_usec - next_at;
               pace = ((64'(r.head_length) + 64'(dlps_pkg::OVERHEAD_BYTES))
                       * 64'(dlps_pkg::PACE_SCALE)) / 64'(bw);
               // A link that has fallen far behind restarts its schedule from now.
               next_at = (late > pace) ? r.now_usec + pace : next_at + pace;
               if (sec)
                  secondary_next_at = next_at;
               else
                  primary_next_at = next_at;
               res.send_now  = 1'b1;
               res.pace_usec = pace[dlps_pkg::PACE_USEC_W-1:0];
            end
         end
         res.use_secondary = have && sec;
      end
      return res;
   endfunction

   function automatic sched_request_type make_request(
         input logic [dlps_pkg::NOW_W-1:0] now,
         input logic [dlps_pkg::DEPTH_W-1:0] depth,
         input logic [dlps_pkg::LEN_W-1:0] len,
         input logic pu, input logic su,
         input logic pt, input logic st);
      sched_request_type r;
      r.now_usec          = now;
      r.queue_depth       = depth;
      r.head_length       = len;
      r.primary_up        = pu;
      r.secondary_up      = su;
      r.primary_testing   = pt;
      r.secondary_testing = st;
      return r;
   endfunction

   // Mostly a plausible packet stream on a moving clock, with some raw noise.
   function automatic sched_request_type next_random_request();
      sched_request_type          r;
      logic [dlps_pkg::NOW_W-1:0] earliest, pace_est, span, thr;
      logic [dlps_pkg::BW_W-1:0]  bw;
      int                         pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         r.now_usec          = {$urandom, $urandom};
         r.queue_depth       = dlps_pkg::DEPTH_W'($urandom);
         r.head_length       = dlps_pkg::LEN_W'($urandom);
         r.primary_up        = 1'($urandom_range(1));
         r.secondary_up      = 1'($urandom_range(1));
         r.primary_testing   = 1'($urandom_range(1));
         r.secondary_testing = 1'($urandom_range(1));
         return r;
      end
      r.head_length = ($urandom_range(99) < 80)
                      ? dlps_pkg::LEN_W'($urandom_range(0, 1500))
                      : dlps_pkg::LEN_W'($urandom);
      earliest = (primary_next_at < secondary_next_at) ? primary_next_at
                                                       : secondary_next_at;
      if (pick < 13) begin
         stream_now = earliest;
      end else if (pick < 15) begin
         stream_now = earliest - 64'd1;
      end else begin
         bw = (link_cfg.primary_bw != '0) ? link_cfg.primary_bw : link_cfg.secondary_bw;
         if (bw == '0)
            bw = 24'd1000;
         pace_est = ((64'(r.head_length) + 64'(dlps_pkg::OVERHEAD_BYTES))
                     * 64'(dlps_pkg::PACE_SCALE)) / 64'(bw);
         span = pace_est * 2 + 2;
         if (span > 64'h7FFF_FFFF)
            span = 64'h7FFF_FFFF;
         stream_now = stream_now + 64'($urandom_range(0, 32'(span)));
      end
      r.now_usec = stream_now;
      thr = depth_threshold() * 2 + 2;
      if (thr > 64'd2047)
         thr = 64'd2047;
      r.queue_depth = ($urandom_range(99) < 10)
                      ? '0
                      : dlps_pkg::DEPTH_W'($urandom_range(1, 32'(thr)));
      r.primary_up        = ($urandom_range(99) < 90);
      r.secondary_up      = ($urandom_range(99) < 90);
      r.primary_testing   = ($urandom_range(99) < 10);
      r.secondary_testing = ($urandom_range(99) < 10);
      return r;
   endfunction

   task automatic send_request(input sched_request_type r);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.now_usec          <= r.now_usec;
      req_ch.queue_depth       <= r.queue_depth;
      req_ch.head_length       <= r.head_length;
      req_ch.primary_up        <= r.primary_up;
      req_ch.secondary_up      <= r.secondary_up;
      req_ch.primary_testing   <= r.primary_testing;
      req_ch.secondary_testing <= r.secondary_testing;
      do
         @(posedge clock);
      while (!req_ch.ready);
      expected_results.push_back(predict_decision(r));
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input logic [dlps_pkg::CSR_IDX_W-1:0] index,
                                 input logic [dlps_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      case (index)
         dlps_pkg::CSR_PRIMARY_BW:
            link_cfg.primary_bw = data[dlps_pkg::BW_W-1:0];
         dlps_pkg::CSR_SECONDARY_BW:
            link_cfg.secondary_bw = data[dlps_pkg::BW_W-1:0];
         dlps_pkg::CSR_PRIMARY_WEIGHT:
            link_cfg.primary_weight = data[dlps_pkg::WEIGHT_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic apply_link_setting(input logic [dlps_pkg::CSR_DATA_W-1:0] pbw,
                                     input logic [dlps_pkg::CSR_DATA_W-1:0] sbw,
                                     input logic [dlps_pkg::CSR_DATA_W-1:0] weight);
      wait_drained();
      write_register(dlps_pkg::CSR_PRIMARY_BW, pbw);
      write_register(dlps_pkg::CSR_SECONDARY_BW, sbw);
      write_register(dlps_pkg::CSR_PRIMARY_WEIGHT, weight);
   endtask

   function automatic logic [dlps_pkg::CSR_DATA_W-1:0] pick_bandwidth();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 24'd10000000;
         2:       return 24'hFFFFFF;
         3:       return dlps_pkg::CSR_DATA_W'($urandom_range(1, 100));
         default: return dlps_pkg::CSR_DATA_W'($urandom_range(1000, 100000));
      endcase
   endfunction

   function automatic logic [dlps_pkg::CSR_DATA_W-1:0] pick_weight();
      case ($urandom_range(9))
         0, 1, 2, 3: return '0;
         4:          return 24'h00FFFF;
         5:          return 24'hFFFFFF;
         default:    return dlps_pkg::CSR_DATA_W'($urandom_range(1, 64));
      endcase
   endfunction

   // The upper data bits of the weight write must be dropped, and the spare index
   // must change nothing.
   task automatic test_register_writes();
      apply_link_setting(24'd10000, 24'd5000, 24'hFF0004);
      write_register(CSR_UNUSED_INDEX, 24'hFFFFFF);
      send_request(make_request(64'd500, 11'd3, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd500, 11'd4, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
   endtask

   task automatic test_directed_cases();
      // Empty queue, then no usable link because links are down or under test
      send_request(make_request(64'd1000, 11'd0, 16'd100, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd1000, 11'd5, 16'd100, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(64'd1000, 11'd5, 16'd100, 1'b1, 1'b0, 1'b1, 1'b0));
      send_request(make_request(64'd1000, 11'd5, 16'd100, 1'b0, 1'b1, 1'b0, 1'b1));
      // Primary below the threshold, then secondary while primary is not yet due
      send_request(make_request(64'd1000, 11'd3, 16'd1480, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd1100, 11'd4, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd1110, 11'd4, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd1200, 11'd4, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      // Depth beyond the nominal queue size and the longest head packet
      send_request(make_request(64'd1300, 11'h7FF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd90000, 11'd1024, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0));
      // The next send time wraps past the top of the clock
      send_request(make_request(64'hFFFF_FFFF_FFFF_FFF0, 11'd1, 16'hFFFF,
                                1'b1, 1'b0, 1'b0, 1'b0));
      send_request(make_request(64'd0, 11'd1, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      // Threshold derived from the primary bandwidth: 8000 / 80 = 100
      apply_link_setting(24'd8000, 24'hFFFFFF, 24'd0);
      send_request(make_request(64'd50000, 11'd99, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd50000, 11'd100, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd50001, 11'd100, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      // Slowest rate gives the longest pacing time
      apply_link_setting(24'd1, 24'd10000000, 24'h00FFFF);
      send_request(make_request(64'd60000, 11'd1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd60001, 11'h7FF, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd60002, 11'd1, 16'd7, 1'b0, 1'b1, 1'b0, 1'b0));
      apply_link_setting(24'd0, 24'd0, 24'd0);
      send_request(make_request(64'd70000, 11'd1, 16'd10, 1'b1, 1'b1, 1'b0, 1'b0));
      apply_link_setting(24'hFFFFFF, 24'd0, 24'd1);
      send_request(make_request(64'd80000, 11'd1, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_request(make_request(64'd80000, 11'd1, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
   endtask

   // Each change of setting also makes the sender pause until all results are in.
   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input int items);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < items; i++) begin
         if (i % ITEMS_PER_CONFIG == 0)
            apply_link_setting(pick_bandwidth(), pick_bandwidth(), pick_weight());
         send_request(next_random_request());
      end
      wait_drained();
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the
   // block fills and must hold off its input.
   task automatic test_input_backpressure();
      apply_link_setting(24'd20000, 24'd12000, 24'd0);
      req_gap_pct       = 0;
      rsp_stall_pct     = 0;
      long_hold_pending = 1'b1;
      for (int i = 0; i < 30; i++)
         send_request(next_random_request());
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.send_now === 1'b1)
            sends_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("result with no request outstanding", 64'd0,
                            64'(rsp_ch.pace_usec));
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_ch.send_now !== oldest_result.send_now)
               report_mismatch("send_now", 64'(oldest_result.send_now),
                               64'(rsp_ch.send_now));
            if (rsp_ch.use_secondary !== oldest_result.use_secondary)
               report_mismatch("use_secondary", 64'(oldest_result.use_secondary),
                               64'(rsp_ch.use_secondary));
            if (rsp_ch.pace_usec !== oldest_result.pace_usec)
               report_mismatch("pace_usec", 64'(oldest_result.pace_usec),
                               64'(rsp_ch.pace_usec));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request, result or register write for %0d cycles",
                     idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      clock                    = 1'b0;
      reset                    = 1'b1;
      req_ch.valid             = 1'b0;
      req_ch.now_usec          = '0;
      req_ch.queue_depth       = '0;
      req_ch.head_length       = '0;
      req_ch.primary_up        = 1'b0;
      req_ch.secondary_up      = 1'b0;
      req_ch.primary_testing   = 1'b0;
      req_ch.secondary_testing = 1'b0;
      rsp_ch.ready             = 1'b0;
      csr_ch.valid             = 1'b0;
      csr_ch.index             = '0;
      csr_ch.data              = '0;
      link_cfg                 = '0;
      primary_next_at          = '0;
      secondary_next_at        = '0;
      stream_now               = '0;
      req_gap_pct              = 0;
      rsp_stall_pct            = 0;
      long_hold_pending        = 1'b0;
      hold_left                = 0;
      idle_cycles              = 0;
      mismatch_count           = 0;
      requests_sent            = 0;
      results_seen             = 0;
      sends_seen               = 0;
      csr_writes               = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_writes();
      test_directed_cases();
      test_random_traffic(21, 86, ITEMS_PER_PHASE);
      test_random_traffic(86, 21, ITEMS_PER_PHASE);
      test_random_traffic(0, 0, ITEMS_PER_PHASE);
      test_input_backpressure();

      wait_drained();
      repeat (END_SETTLE) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", 64'(expected_results.size()), 64'd0);
      $display("Checked %0d requests over %0d register writes; %0d results, %0d sends.",
               requests_sent, csr_writes, results_seen, sends_seen);
      $display("Traffic ran with sender gaps, receiver stalls, a long receiver hold-off and %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
